>>> src/mch_pkg.sv
// Shared types, constants and the arctangent threshold tables for the compass heading block.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mch_pkg;

    localparam int RAW_W      = 16;
    localparam int OFS_W      = 12;
    localparam int DEC_W      = 10;
    localparam int HEAD_W     = 9;
    localparam int CORR_W     = RAW_W + 1;
    localparam int MAG_W      = RAW_W;
    localparam int DEG_MAX    = 90;
    localparam int DEG_W      = 7;
    localparam int QBITS      = 30;
    localparam int NTERMS     = 15;
    localparam int TRIG_W     = QBITS + 1;
    localparam int PROD_W     = MAG_W + TRIG_W;
    localparam int FRAC_W     = 4;
    localparam int SUM_W      = HEAD_W + FRAC_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 2'd2;

    localparam logic signed [OFS_W-1:0] X_OFFSET_RST    = 12'sd17;
    localparam logic signed [OFS_W-1:0] Y_OFFSET_RST    = -12'sd171;
    localparam logic signed [DEC_W-1:0] DECLINATION_RST = 10'sd0;

    localparam logic [HEAD_W-1:0] FULL_TURN  = 9'd360;
    localparam logic [HEAD_W-1:0] HALF_TURN  = 9'd180;
    localparam logic [DEG_W-1:0]  NORTH_LOW  = 7'd5;
    localparam logic [DEG_W-1:0]  PROBE_FIRST = DEG_W'(1) << (DEG_W - 1);

    typedef logic [TRIG_W-1:0]            t_trig;
    typedef logic [DEG_MAX:0][TRIG_W-1:0] t_trig_tab;

    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             x_pos;
        logic             y_pos;
        logic [DEG_W-1:0] deg;
        logic [DEG_W-1:0] probe;
    } t_item;

    // restoring long division, shift and subtract
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_trig_tab build_tab(input logic want_cos);
        t_trig_tab          tab;
        logic [63:0]        theta;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic [63:0]        dv;
        logic signed [63:0] acc;
        int                 sh;
        tab = '0;
        sh  = want_cos ? 0 : 1;
        tab[0] = want_cos ? TRIG_W'(64'd1 << QBITS) : '0;
        for (int d = 1; d <= DEG_MAX; d++) begin
            theta = udiv((64'(d) * 64'd628 << QBITS) + 64'd18000, 64'd36000);
            th2   = (theta * theta) >> QBITS;
            term  = want_cos ? (64'd1 << QBITS) : theta;
            acc   = signed'(term);
            for (int k = 1; k <= NTERMS; k++) begin
                dv   = 64'(2 * k - 1 + sh) * 64'(2 * k + sh);
                term = udiv((term * th2) >> QBITS, dv);
                if (k[0]) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            tab[d] = (acc < 0) ? '0 : acc[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = build_tab(1'b0);
    localparam t_trig_tab COS_TAB = build_tab(1'b1);

endpackage

`default_nettype wire

>>> src/mch_front.sv
// Input stage: hard-iron correction, x negation, magnitudes and sign flags.
// Depends on mch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mch_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic signed [mch_pkg::RAW_W-1:0]   i_field_x,
    input  wire logic signed [mch_pkg::RAW_W-1:0]   i_field_y,
    input  wire logic signed [mch_pkg::OFS_W-1:0]   i_x_offset,
    input  wire logic signed [mch_pkg::OFS_W-1:0]   i_y_offset,
    output logic                                    o_valid,
    output mch_pkg::t_item                          o_item
);

    logic signed [mch_pkg::CORR_W-1:0] x_corr;
    logic signed [mch_pkg::CORR_W-1:0] y_corr;
    logic [mch_pkg::CORR_W-1:0]        x_abs;
    logic [mch_pkg::CORR_W-1:0]        y_abs;
    mch_pkg::t_item                    n_item;
    logic                              r_valid;
    mch_pkg::t_item                    r_item;

    always_comb begin
        x_corr = mch_pkg::CORR_W'(i_x_offset) - mch_pkg::CORR_W'(i_field_x);
        y_corr = mch_pkg::CORR_W'(i_field_y) - mch_pkg::CORR_W'(i_y_offset);
        x_abs  = x_corr[mch_pkg::CORR_W-1] ? mch_pkg::CORR_W'(-x_corr) : x_corr;
        y_abs  = y_corr[mch_pkg::CORR_W-1] ? mch_pkg::CORR_W'(-y_corr) : y_corr;
        n_item.ax    = x_abs[mch_pkg::MAG_W-1:0];
        n_item.ay    = y_abs[mch_pkg::MAG_W-1:0];
        n_item.x_pos = (x_corr > 0);
        n_item.y_pos = (y_corr > 0);
        n_item.deg   = '0;
        n_item.probe = mch_pkg::PROBE_FIRST;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> src/mch_step.sv
// One bit of the angle search: table read, two threshold products, compare and update.
// Three register stages; depends on mch_pkg for the sine and cosine tables.
`timescale 1ns / 1ps
`default_nettype none

module mch_step (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  mch_pkg::t_item  i_item,
    output logic            o_valid,
    output mch_pkg::t_item  o_item
);

    logic [mch_pkg::DEG_W-1:0]  cand;
    logic                       in_range;
    mch_pkg::t_trig             sin_sel;
    mch_pkg::t_trig             cos_sel;
    mch_pkg::t_item             n_item3;

    logic                       r_v1;
    mch_pkg::t_item             r_it1;
    logic [mch_pkg::DEG_W-1:0]  r_cand1;
    logic                       r_inr1;
    mch_pkg::t_trig             r_sin1;
    mch_pkg::t_trig             r_cos1;

    logic                       r_v2;
    mch_pkg::t_item             r_it2;
    logic [mch_pkg::DEG_W-1:0]  r_cand2;
    logic                       r_inr2;
    logic [mch_pkg::PROD_W-1:0] r_pa2;
    logic [mch_pkg::PROD_W-1:0] r_pb2;

    logic                       r_v3;
    mch_pkg::t_item             r_it3;

    always_comb begin
        cand     = i_item.deg | i_item.probe;
        in_range = (cand <= mch_pkg::DEG_W'(mch_pkg::DEG_MAX));
        sin_sel  = in_range ? mch_pkg::SIN_TAB[cand] : '0;
        cos_sel  = in_range ? mch_pkg::COS_TAB[cand] : '0;
    end

    always_comb begin
        n_item3       = r_it2;
        n_item3.probe = r_it2.probe >> 1;
        if (r_inr2 && (r_pa2 >= r_pb2)) begin
            n_item3.deg = r_cand2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it1   <= i_item;
            r_cand1 <= cand;
            r_inr1  <= in_range;
            r_sin1  <= sin_sel;
            r_cos1  <= cos_sel;
            r_it2   <= r_it1;
            r_cand2 <= r_cand1;
            r_inr2  <= r_inr1;
            r_pa2   <= mch_pkg::PROD_W'(r_it1.ay) * mch_pkg::PROD_W'(r_cos1);
            r_pb2   <= mch_pkg::PROD_W'(r_it1.ax) * mch_pkg::PROD_W'(r_sin1);
            r_it3   <= n_item3;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;

endmodule

`default_nettype wire

>>> src/mch_back.sv
// Output end: quadrant mapping, declination, single wrap, output register and skid stage.
// Depends on mch_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mch_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  mch_pkg::t_item                         i_item,
    input  wire logic signed [mch_pkg::DEC_W-1:0]  i_declination,
    input  wire logic                              i_ready,
    output logic                                   o_valid,
    output logic [mch_pkg::HEAD_W-1:0]             o_heading,
    output logic                                   o_en
);

    logic [mch_pkg::HEAD_W-1:0]                deg9;
    logic [mch_pkg::HEAD_W-1:0]                base;
    logic signed [mch_pkg::SUM_W-1:0]          sum;
    logic signed [mch_pkg::SUM_W-1:0]          sum_tz;
    logic [mch_pkg::SUM_W-mch_pkg::FRAC_W-1:0] whole_s;
    logic [mch_pkg::HEAD_W-1:0]                whole;
    logic [mch_pkg::HEAD_W-1:0]                heading;
    logic                                      deliver;
    logic                                      take;

    logic                             r_out_v;
    logic [mch_pkg::HEAD_W-1:0]       r_out;
    logic                             r_skid_v;
    logic [mch_pkg::HEAD_W-1:0]       r_skid;

    always_comb begin
        deg9 = mch_pkg::HEAD_W'(i_item.deg);
        if (i_item.x_pos && i_item.y_pos) begin
            base = (i_item.deg < mch_pkg::NORTH_LOW) ? deg9 + mch_pkg::FULL_TURN : deg9;
        end else if (!i_item.x_pos && i_item.y_pos) begin
            base = mch_pkg::HALF_TURN - deg9;
        end else if (!i_item.x_pos) begin
            base = mch_pkg::HALF_TURN + deg9;
        end else begin
            base = mch_pkg::FULL_TURN - deg9;
        end
        sum     = $signed({1'b0, base, {mch_pkg::FRAC_W{1'b0}}})
                + mch_pkg::SUM_W'(i_declination);
        // bias a negative sum so the shift truncates toward zero
        sum_tz  = sum + $signed({{(mch_pkg::SUM_W-mch_pkg::FRAC_W){1'b0}},
                                 {mch_pkg::FRAC_W{sum[mch_pkg::SUM_W-1]}}});
        whole_s = sum_tz[mch_pkg::SUM_W-1:mch_pkg::FRAC_W];
        whole   = whole_s[mch_pkg::HEAD_W-1:0];
        if (whole_s[mch_pkg::SUM_W-mch_pkg::FRAC_W-1]) begin
            whole = whole + mch_pkg::FULL_TURN;
        end
        heading = (whole > mch_pkg::FULL_TURN) ? whole - mch_pkg::FULL_TURN : whole;
    end

    assign o_en    = !r_skid_v;
    assign deliver = o_en && i_valid;
    assign take    = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= deliver;
            end
        end else if (deliver) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || take) begin
            r_out <= r_skid_v ? r_skid : heading;
        end else if (deliver) begin
            r_skid <= heading;
        end
    end

    assign o_valid   = r_out_v;
    assign o_heading = r_out;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !take) |=> (r_skid_v && $stable(r_skid)))
        else $error("skid beat lost or altered while stalled");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out <= mch_pkg::FULL_TURN))
        else $error("heading outside a full turn");

    a_no_deliver_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready && deliver) |=> r_skid_v)
        else $error("beat from the pipeline dropped while output stalled");
`endif

endmodule

`default_nettype wire

>>> src/magnetometer_compass_heading.sv
// Compass heading from one magnetometer x/y sample pair.
// Input channel (i_valid/o_ready) takes one beat of raw x and y; output channel
// (o_valid/i_ready) returns one beat holding the heading in whole degrees, 0 to 360.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high
// (0 x offset, 1 y offset, 2 declination in degrees with four fraction bits);
// write only while no beat is in flight.
// Throughput: one beat per cycle while o_ready is high. The path from input accept to
// o_valid runs through the correction stage, the seven-step angle search of three stages
// each (table read, the two threshold products, compare) and the output register.
// Reset (synchronous, active low) empties the pipeline and loads the offsets 17 and
// -171 and a zero declination.
// A stalled receiver holds its beat in the output register; one more beat lands in
// the skid stage, after which o_ready falls and the whole pipeline holds in place
// until the output beat is taken. Nothing is dropped or repeated.
// Depends on mch_pkg, mch_front, mch_step and mch_back.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_compass_heading (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [mch_pkg::RAW_W-1:0]       i_field_x,
    input  wire logic signed [mch_pkg::RAW_W-1:0]       i_field_y,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [mch_pkg::HEAD_W-1:0]                  o_heading,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mch_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [mch_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic signed [mch_pkg::OFS_W-1:0] r_x_offset;
    logic signed [mch_pkg::OFS_W-1:0] r_y_offset;
    logic signed [mch_pkg::DEC_W-1:0] r_declination;
    logic                             en;
    logic                             w_v    [0:mch_pkg::DEG_W];
    mch_pkg::t_item                   w_item [0:mch_pkg::DEG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset    <= mch_pkg::X_OFFSET_RST;
            r_y_offset    <= mch_pkg::Y_OFFSET_RST;
            r_declination <= mch_pkg::DECLINATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mch_pkg::CFG_X_OFFSET: begin
                    r_x_offset <= i_cfg_data;
                end
                mch_pkg::CFG_Y_OFFSET: begin
                    r_y_offset <= i_cfg_data;
                end
                mch_pkg::CFG_DECLINATION: begin
                    r_declination <= i_cfg_data[mch_pkg::DEC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ready = en;

    mch_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_field_x  (i_field_x),
        .i_field_y  (i_field_y),
        .i_x_offset (r_x_offset),
        .i_y_offset (r_y_offset),
        .o_valid    (w_v[0]),
        .o_item     (w_item[0])
    );

    for (genvar g = 0; g < mch_pkg::DEG_W; g++) begin : g_step
        mch_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_v[g]),
            .i_item  (w_item[g]),
            .o_valid (w_v[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    mch_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_v[mch_pkg::DEG_W]),
        .i_item        (w_item[mch_pkg::DEG_W]),
        .i_declination (r_declination),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_heading     (o_heading),
        .o_en          (en)
    );

`ifndef NO_ASSERTIONS
    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[mch_pkg::DEG_W] |-> (w_item[mch_pkg::DEG_W].probe == '0))
        else $error("angle search left a probe bit unused");

    a_degree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[mch_pkg::DEG_W] |->
            (w_item[mch_pkg::DEG_W].deg <= mch_pkg::DEG_W'(mch_pkg::DEG_MAX)))
        else $error("angle above a quarter turn");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(w_v[0]) && $stable(w_item[0])))
        else $error("front stage moved while the pipeline was held");
`endif

endmodule

`default_nettype wire
